// File: src/ltp_pkg.sv
// ----------------------------------------------------------------------------
// ltp_pkg
// Shared types and constants for the twin prime range search block:
// controller states, command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ltp_pkg;

  // default width of the range values inside the block
  localparam int LTP_VALUE_WIDTH = 16;
  // fixed width of the port fields
  localparam int LTP_FIELD_W = 16;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_INIT,
    ST_CHECK,
    ST_REM,
    ST_PASS,
    ST_FAIL,
    ST_DONE
  } state_t;

  // which value is under primality test: the candidate or one of its neighbors
  typedef enum logic [1:0] {
    TGT_SELF,
    TGT_BELOW,
    TGT_ABOVE
  } tgt_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_range;
    logic init_test;
    tgt_t tgt;
    logic start_rem;
    logic step_div;
    logic dec_v;
    logic load_out;
    logic out_found;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic n_lt2;
    logic sq_gt_n;
    logic rem_done;
    logic rem_zero;
    logic v_eq_lo;
  } sts_t;

endpackage

// File: src/largest_twin_prime_in_range_unit.sv
// ----------------------------------------------------------------------------
// largest_twin_prime_in_range_unit
// Scans a range downward and reports the largest twin prime in it, using
// trial division through an iterative remainder unit.
// ----------------------------------------------------------------------------
// flow: an empty range is reported straight after the range check; otherwise each
//   tested value goes through trial division, one dividend bit per cycle in the
//   remainder unit; a new result waits in ST_DONE while the previous one is unread
// throughput: one word in flight; the next word is taken once the result
//   is in the output register, while that result waits to be read
// reset: synchronous active-low rst_n clears the controller and output valid
module largest_twin_prime_in_range_unit #(
  parameter int VALUE_WIDTH = ltp_pkg::LTP_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ltp_pkg::LTP_FIELD_W-1:0]  in_range_low,
  input  logic [ltp_pkg::LTP_FIELD_W-1:0]  in_range_high,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [ltp_pkg::LTP_FIELD_W-1:0]  out_twin_prime
);

  import ltp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  ltp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  ltp_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .range_low  (in_range_low),
    .range_high (in_range_high),
    .res_found  (out_found),
    .res_value  (out_twin_prime)
  );

  // one word at a time: no new word right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous one in progress");

  // value reads zero when nothing was found
  a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_twin_prime == '0)
    else $error("nonzero value with found low");

  // a result only appears after a word was taken in the earlier cycles
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised straight out of idle");

endmodule

// File: src/ltp_rem.sv
// ----------------------------------------------------------------------------
// ltp_rem
// Iterative remainder unit: restoring division that brings in one dividend
// bit per cycle and keeps only the remainder.
// ----------------------------------------------------------------------------
module ltp_rem #(
  parameter int NW = 17,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic          rem_zero
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   div_ext;

  assign div_ext = {1'b0, div_r};
  assign trial   = {rem_r, num_r[NW-1]};

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      num_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (trial >= div_ext) begin
        rem_nxt = DW'(trial - div_ext);
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

// File: src/ltp_dp.sv
// ----------------------------------------------------------------------------
// ltp_dp
// Datapath: range and candidate registers, trial divisor and its square,
// remainder unit and the result word register.
// ----------------------------------------------------------------------------
module ltp_dp #(
  parameter int VALUE_WIDTH = ltp_pkg::LTP_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ltp_pkg::cmd_t                cmd,
  output ltp_pkg::sts_t                sts,
  input  logic [ltp_pkg::LTP_FIELD_W-1:0] range_low,
  input  logic [ltp_pkg::LTP_FIELD_W-1:0] range_high,
  output logic                         res_found,
  output logic [ltp_pkg::LTP_FIELD_W-1:0] res_value
);

  import ltp_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int FW = LTP_FIELD_W;
  // tested values reach the candidate plus two
  localparam int TW = VW + 1;
  localparam int DW = (TW + 1) / 2 + 1;
  localparam int SW = TW + 2;

  logic [VW+FW-1:0] low_ext, high_ext;
  logic [VW+FW-1:0] v_out_ext;
  logic [VW-1:0]    lo_r, lo_nxt;
  logic [VW-1:0]    v_r, v_nxt;
  logic [TW-1:0]    n_r, n_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [SW-1:0]    sq_r, sq_nxt;
  logic [TW-1:0]    v_tw;
  logic [TW-1:0]    target;
  logic             found_r, found_nxt;
  logic [FW-1:0]    value_r, value_nxt;
  logic             rem_done, rem_zero;

  // fit port fields to the internal width
  assign low_ext   = {{VW{1'b0}}, range_low};
  assign high_ext  = {{VW{1'b0}}, range_high};
  assign v_out_ext = {{FW{1'b0}}, v_r};

  // value under test
  assign v_tw = {1'b0, v_r};
  always_comb begin
    case (cmd.tgt)
      TGT_SELF:  target = v_tw;
      TGT_BELOW: target = v_tw - TW'(2);
      TGT_ABOVE: target = v_tw + TW'(2);
      default:   target = v_tw;
    endcase
  end

  // register updates
  always_comb begin
    lo_nxt    = lo_r;
    v_nxt     = v_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    found_nxt = found_r;
    value_nxt = value_r;
    if (cmd.load_range) begin
      lo_nxt = low_ext[VW-1:0];
      v_nxt  = high_ext[VW-1:0];
    end
    if (cmd.dec_v) begin
      v_nxt = v_r - VW'(1);
    end
    if (cmd.init_test) begin
      n_nxt  = target;
      d_nxt  = DW'(2);
      sq_nxt = SW'(4);
    end
    // (d+1)^2 = d^2 + 2d + 1
    if (cmd.step_div) begin
      d_nxt  = d_r + DW'(1);
      sq_nxt = sq_r + {{(SW-DW-1){1'b0}}, d_r, 1'b1};
    end
    if (cmd.load_out) begin
      found_nxt = cmd.out_found;
      value_nxt = cmd.out_found ? v_out_ext[FW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    v_r     <= v_nxt;
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    found_r <= found_nxt;
    value_r <= value_nxt;
  end

  // remainder of test value by trial divisor
  ltp_rem #(
    .NW (TW),
    .DW (DW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_rem),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  // status back to the controller
  always_comb begin
    sts.empty    = (lo_r > v_r);
    sts.n_lt2    = (n_r < TW'(2));
    sts.sq_gt_n  = (sq_r > {1'b0, 1'b0, n_r});
    sts.rem_done = rem_done;
    sts.rem_zero = rem_zero;
    sts.v_eq_lo  = (v_r == lo_r);
  end

  assign res_found = found_r;
  assign res_value = value_r;

endmodule

// File: src/ltp_ctrl.sv
// ----------------------------------------------------------------------------
// ltp_ctrl
// Controller: walks candidates downward, runs the primality test on the
// candidate and its neighbors, and handles both handshakes.
// ----------------------------------------------------------------------------
module ltp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ltp_pkg::sts_t sts,
  output ltp_pkg::cmd_t cmd
);

  import ltp_pkg::*;

  state_t state_r, state_nxt;
  tgt_t   tgt_r, tgt_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   found_r, found_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tgt_r       <= TGT_SELF;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.tgt       = tgt_r;
    cmd.out_found = found_r;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_range = 1'b1;
          state_nxt      = ST_RANGE;
        end
      end
      ST_RANGE: begin
        tgt_nxt = TGT_SELF;
        if (sts.empty) begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_test = 1'b1;
        state_nxt     = ST_CHECK;
      end
      // prime once the divisor square passes the value
      ST_CHECK: begin
        if (sts.n_lt2) begin
          state_nxt = ST_FAIL;
        end else if (sts.sq_gt_n) begin
          state_nxt = ST_PASS;
        end else begin
          cmd.start_rem = 1'b1;
          state_nxt     = ST_REM;
        end
      end
      ST_REM: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            state_nxt = ST_FAIL;
          end else begin
            cmd.step_div = 1'b1;
            state_nxt    = ST_CHECK;
          end
        end
      end
      ST_PASS: begin
        if (tgt_r == TGT_SELF) begin
          tgt_nxt   = TGT_BELOW;
          state_nxt = ST_INIT;
        end else begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_FAIL: begin
        if (tgt_r == TGT_BELOW) begin
          tgt_nxt   = TGT_ABOVE;
          state_nxt = ST_INIT;
        end else if (sts.v_eq_lo) begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          // next candidate down
          cmd.dec_v = 1'b1;
          tgt_nxt   = TGT_SELF;
          state_nxt = ST_INIT;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
